### rtl/skl_pkg.sv
// ----------------------------------------------------------------------------
// skl_pkg - shared constants and types for the soft-knee limiter
// Default input format, quotient width, PCM width and the item tag that
// travels beside the arithmetic through every pipeline stage.
// ----------------------------------------------------------------------------
package skl_pkg;

  // Default input format: Q3.20 in 24 bits
  localparam int IN_WIDTH_DEF = 24;
  localparam int IN_FRAC_DEF  = 20;

  // PCM output and quotient widths (magnitude never exceeds 32767)
  localparam int PCM_WIDTH = 16;
  localparam int Q_BITS    = 15;

  // The PCM scale 32767.5 is applied as 65535 / 2, and 65535 = 2^16 - 1
  localparam int SCALE_SHIFT = 16;

  // Sign and frame marker carried with each request
  typedef struct packed {
    logic neg;
    logic last;
  } skl_tag_t;

  // Internal base width: wide enough for the magnitude and for 2.0 in the input format
  function automatic int base_width(input int in_width, input int in_frac);
    base_width = (in_width > in_frac + 1) ? in_width : in_frac + 2;
  endfunction

endpackage

### rtl/soft_knee_limiter_to_pcm16.sv
// ----------------------------------------------------------------------------
// soft_knee_limiter_to_pcm16 - soft-knee limiter with 16-bit PCM output
// Limits a fixed-point mix sample with a rational soft knee at 0.8 and
// scales the result to signed 16-bit PCM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sample per request: tdata holds the signed sample
//   (IN_WIDTH bits, IN_FRAC fraction bits, zero padded to whole bytes) and
//   tlast marks the final frame of a render block.
//   m_axis returns one PCM sample per request in tdata[15:0], with tlast
//   copied from the matching input.
//   A sample passes four operand stages, one stage per quotient bit of the
//   15-bit restoring divider and the output register. A new sample is
//   taken every cycle unless every stage is full and the receiver stalls;
//   the divider pipeline, one trial subtract per stage, allows that rate.
//   Each stage has its own valid bit and takes a new request whenever it is
//   empty or its successor takes its contents, so bubbles close up while the
//   receiver stalls and tready falls only once every stage is full.
//   Synchronous reset empties the pipeline; no request in flight survives.
// ----------------------------------------------------------------------------
module soft_knee_limiter_to_pcm16 #(
  parameter int IN_WIDTH = skl_pkg::IN_WIDTH_DEF,
  parameter int IN_FRAC  = skl_pkg::IN_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [IN_WIDTH-1:0] sample_in, zero padded above
  input  logic [((IN_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] pcm_out
  output logic [skl_pkg::PCM_WIDTH-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import skl_pkg::*;

  localparam int BW = base_width(IN_WIDTH, IN_FRAC);
  localparam int NW = BW + 21;
  localparam int DW = BW + 6;

  // Divider chain: index k is the input of step k, index Q_BITS its end
  logic              vld [0:Q_BITS];
  logic              rdy [0:Q_BITS];
  skl_tag_t          tag [0:Q_BITS];
  logic [NW-1:0]     rem [0:Q_BITS];
  logic [DW-1:0]     den [0:Q_BITS];
  logic [Q_BITS-1:0] quo [0:Q_BITS];

  // Operand preparation
  skl_front #(
    .IN_WIDTH  (IN_WIDTH),
    .IN_FRAC   (IN_FRAC),
    .NUM_WIDTH (NW),
    .DEN_WIDTH (DW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .sample    (s_axis_tdata[IN_WIDTH-1:0]),
    .last      (s_axis_tlast),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .tag_out   (tag[0]),
    .num       (rem[0]),
    .den       (den[0])
  );

  assign quo[0] = '0;

  // Restoring divider, most significant quotient bit first
  for (genvar k = 0; k < Q_BITS; k++) begin : g_div
    skl_div_step #(
      .NUM_WIDTH (NW),
      .DEN_WIDTH (DW),
      .BIT_POS   (Q_BITS - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .tag_in    (tag[k]),
      .rem_in    (rem[k]),
      .den_in    (den[k]),
      .q_in      (quo[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .tag_out   (tag[k+1]),
      .rem_out   (rem[k+1]),
      .den_out   (den[k+1]),
      .q_out     (quo[k+1])
    );
  end

  // Sign restore and output register
  skl_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[Q_BITS]),
    .in_ready  (rdy[Q_BITS]),
    .tag_in    (tag[Q_BITS]),
    .q_in      (quo[Q_BITS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pcm       (m_axis_tdata),
    .last      (m_axis_tlast)
  );

endmodule

### rtl/skl_front.sv
// ----------------------------------------------------------------------------
// skl_front - magnitude, knee test and division operands
// Four register stages: absolute value, knee test and excess over the knee,
// rational numerator and denominator terms, final scaled dividend/divisor.
// ----------------------------------------------------------------------------
module skl_front #(
  parameter int IN_WIDTH  = skl_pkg::IN_WIDTH_DEF,
  parameter int IN_FRAC   = skl_pkg::IN_FRAC_DEF,
  parameter int NUM_WIDTH = skl_pkg::base_width(IN_WIDTH, IN_FRAC) + 21,
  parameter int DEN_WIDTH = skl_pkg::base_width(IN_WIDTH, IN_FRAC) + 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [IN_WIDTH-1:0]   sample,
  input  logic                  last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output skl_pkg::skl_tag_t     tag_out,
  output logic [NUM_WIDTH-1:0]  num,
  output logic [DEN_WIDTH-1:0]  den
);
  import skl_pkg::*;

  localparam int BW = base_width(IN_WIDTH, IN_FRAC);
  localparam int XW = BW + 5;
  localparam logic [BW+2:0] ONE      = (BW+3)'(1) << IN_FRAC;
  localparam logic [BW+2:0] FOUR_ONE = (BW+3)'(1) << (IN_FRAC + 2);

  // Stage A: magnitude
  logic              a_vld, a_ready;
  skl_tag_t          a_tag;
  logic [BW-1:0]     a_mag;
  logic [IN_WIDTH-1:0] mag_in;

  // Stage B: knee test and excess
  logic              b_vld, b_ready;
  skl_tag_t          b_tag;
  logic [BW-1:0]     b_mag;
  logic              b_knee;
  logic [BW+2:0]     b_d;
  logic [BW+2:0]     five_a;

  // Stage C: numerator term and denominator term
  logic              c_vld, c_ready;
  skl_tag_t          c_tag;
  logic              c_knee;
  logic [XW-1:0]     c_x;
  logic [BW+2:0]     c_s;

  // Stage D: output registers
  logic              d_ready;

  assign in_ready = a_ready;
  assign a_ready  = !a_vld || b_ready;
  assign b_ready  = !b_vld || c_ready;
  assign c_ready  = !c_vld || d_ready;
  assign d_ready  = !out_valid || out_ready;

  // Take the magnitude; the most negative code maps to 2^(IN_WIDTH-1) exactly
  assign mag_in = sample[IN_WIDTH-1] ? (~sample + 1'b1) : sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (a_ready) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_tag.neg  <= sample[IN_WIDTH-1];
      a_tag.last <= last;
      a_mag      <= BW'(mag_in);
    end
  end

  // Compare 5*|x| against 4.0 (knee at 0.8) and form the excess d
  assign five_a = ((BW+3)'(a_mag) << 2) + (BW+3)'(a_mag);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (b_ready) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_vld) begin
      b_tag  <= a_tag;
      b_mag  <= a_mag;
      b_knee <= (five_a <= FOUR_ONE);
      b_d    <= five_a - FOUR_ONE;
    end
  end

  // Above the knee: x = 4*ONE + 5*d, s = ONE + d; below it x is the magnitude
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (c_ready) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_vld) begin
      c_tag  <= b_tag;
      c_knee <= b_knee;
      c_x    <= b_knee ? XW'(b_mag)
                       : XW'(FOUR_ONE) + (XW'(b_d) << 2) + XW'(b_d);
      c_s    <= ONE + b_d;
    end
  end

  // Scale by 65535 and build the divisor: 2*ONE below the knee, 10*s above
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (d_ready) begin
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_vld) begin
      tag_out <= c_tag;
      num     <= (NUM_WIDTH'(c_x) << SCALE_SHIFT) - NUM_WIDTH'(c_x);
      den     <= c_knee ? (DEN_WIDTH'(ONE) << 1)
                        : (DEN_WIDTH'(c_s) << 3) + (DEN_WIDTH'(c_s) << 1);
    end
  end

endmodule

### rtl/skl_div_step.sv
// ----------------------------------------------------------------------------
// skl_div_step - one restoring division stage
// Tries the divisor shifted to one quotient bit position; when the trial
// subtraction fits it keeps the difference as remainder and sets the quotient bit.
// ----------------------------------------------------------------------------
module skl_div_step #(
  parameter int NUM_WIDTH = skl_pkg::base_width(skl_pkg::IN_WIDTH_DEF,
                                                skl_pkg::IN_FRAC_DEF) + 21,
  parameter int DEN_WIDTH = skl_pkg::base_width(skl_pkg::IN_WIDTH_DEF,
                                                skl_pkg::IN_FRAC_DEF) + 6,
  parameter int BIT_POS   = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  skl_pkg::skl_tag_t           tag_in,
  input  logic [NUM_WIDTH-1:0]        rem_in,
  input  logic [DEN_WIDTH-1:0]        den_in,
  input  logic [skl_pkg::Q_BITS-1:0]  q_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output skl_pkg::skl_tag_t           tag_out,
  output logic [NUM_WIDTH-1:0]        rem_out,
  output logic [DEN_WIDTH-1:0]        den_out,
  output logic [skl_pkg::Q_BITS-1:0]  q_out
);
  import skl_pkg::*;

  logic [NUM_WIDTH-1:0] trial;
  logic                 fits;

  assign in_ready = !out_valid || out_ready;

  // Trial subtract of the divisor at this bit position
  assign trial = NUM_WIDTH'(den_in) << BIT_POS;
  assign fits  = (rem_in >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance remainder, divisor and partial quotient
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      tag_out <= tag_in;
      den_out <= den_in;
      rem_out <= fits ? (rem_in - trial) : rem_in;
      q_out   <= q_in | (Q_BITS'(fits) << BIT_POS);
    end
  end

endmodule

### rtl/skl_pack.sv
// ----------------------------------------------------------------------------
// skl_pack - sign restore and PCM output register
// Applies the sample sign to the quotient magnitude and holds the result
// until the receiver takes it.
// ----------------------------------------------------------------------------
module skl_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  skl_pkg::skl_tag_t             tag_in,
  input  logic [skl_pkg::Q_BITS-1:0]    q_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [skl_pkg::PCM_WIDTH-1:0] pcm,
  output logic                          last
);
  import skl_pkg::*;

  logic [PCM_WIDTH-1:0] mag;

  assign in_ready = !out_valid || out_ready;

  // The 15-bit quotient stays within 0..32767, so no clamp is needed on either sign
  assign mag = PCM_WIDTH'(q_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Restore the sign; truncation toward zero follows from the magnitude floor
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pcm  <= tag_in.neg ? (~mag + 1'b1) : mag;
      last <= tag_in.last;
    end
  end

endmodule

### tb/skl_pcm_checker.sv
// ----------------------------------------------------------------------------
// skl_pcm_checker - scoreboard for the soft-knee limiter
// Watches both stream channels of the limiter, works out the PCM value and
// frame marker due for every accepted sample, and compares each returned
// request against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module skl_pcm_checker #(
  parameter int IN_WIDTH = skl_pkg::IN_WIDTH_DEF,
  parameter int IN_FRAC  = skl_pkg::IN_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_ready,
  // [IN_WIDTH-1:0] sample_in, zero padded above
  input  logic [((IN_WIDTH+7)/8)*8-1:0] sample_data,
  input  logic                          sample_last,
  input  logic                          pcm_valid,
  input  logic                          pcm_ready,
  // [15:0] pcm_out
  input  logic [skl_pkg::PCM_WIDTH-1:0] pcm_data,
  input  logic                          pcm_last,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  // PCM scale 32767.5 taken as 65535 / 2
  localparam logic [63:0] PCM_SCALE = (64'd1 << SCALE_SHIFT) - 64'd1;
  localparam int          MAX_SHOWN = 30;

  typedef struct packed {
    logic [PCM_WIDTH-1:0] pcm;
    logic                 last;
  } pcm_frame_t;

  pcm_frame_t expected_pcm_q[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Limit one sample with the rational soft knee and scale it to PCM
  function automatic logic [PCM_WIDTH-1:0] limit_to_pcm(input logic [IN_WIDTH-1:0] sample);
    logic [63:0] one;
    logic [63:0] mag;
    logic [63:0] excess;
    logic [63:0] level;
    logic        neg;
    one = 64'd1 << IN_FRAC;
    neg = sample[IN_WIDTH-1];
    // magnitude taken exactly, the most negative sample included
    mag = neg ? (64'd1 << IN_WIDTH) - 64'(sample) : 64'(sample);
    if (64'd5 * mag <= 64'd4 * one) begin
      level = (mag * PCM_SCALE) / (64'd2 * one);
    end else begin
      excess = 64'd5 * mag - 64'd4 * one;
      level  = ((64'd4 * one + 64'd5 * excess) * PCM_SCALE) / (64'd10 * (one + excess));
    end
    // clamp to the range of the sign, then restore the sign
    if (neg) begin
      if (level > 64'd32768) level = 64'd32768;
      return PCM_WIDTH'(64'd0 - level);
    end
    if (level > 64'd32767) level = 64'd32767;
    return PCM_WIDTH'(level);
  endfunction

  // Print one mismatch line (up to a cap) and count it
  task automatic report_mismatch(input string what);
    if (mismatches < MAX_SHOWN) $display("[%0t] pcm check: %s", $time, what);
    mismatches++;
  endtask

  // Retire returned requests first, then queue the newly accepted sample
  always @(posedge clk) begin : track_requests
    pcm_frame_t want;
    if (!rst) begin
      if (pcm_valid && pcm_ready) begin
        if (expected_pcm_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pcm %0d last %0b with nothing outstanding",
                                    $signed(pcm_data), pcm_last));
        end else begin
          want = expected_pcm_q.pop_front();
          if (pcm_data !== want.pcm)
            report_mismatch($sformatf("pcm %0d, expected %0d",
                                      $signed(pcm_data), $signed(want.pcm)));
          if (pcm_last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", pcm_last, want.last));
        end
      end
      if (sample_valid && sample_ready) begin
        want.pcm  = limit_to_pcm(sample_data[IN_WIDTH-1:0]);
        want.last = sample_last;
        expected_pcm_q.push_back(want);
      end
      outstanding <= expected_pcm_q.size();
    end
  end

endmodule

### tb/tb_soft_knee_limiter_to_pcm16.sv
// ----------------------------------------------------------------------------
// tb_soft_knee_limiter_to_pcm16 - testbench for the soft-knee PCM limiter
// Sends corner samples back to back, then random samples biased towards the
// knee, whole unit levels and the extremes, in bursts against a receiver that
// stalls on its own pattern. A separate scoreboard checks every result.
// ----------------------------------------------------------------------------
module tb_soft_knee_limiter_to_pcm16;
  timeunit 1ns;
  timeprecision 1ps;

  import skl_pkg::*;

  localparam int IN_WIDTH       = IN_WIDTH_DEF;
  localparam int IN_FRAC        = IN_FRAC_DEF;
  localparam int TDATA_W        = ((IN_WIDTH + 7) / 8) * 8;
  localparam int ONE            = 1 << IN_FRAC;
  localparam int KNEE           = (4 * ONE) / 5;
  localparam int MAX_POS        = int'((64'd1 << (IN_WIDTH - 1)) - 64'd1);
  localparam int MIN_NEG        = -MAX_POS - 1;
  localparam int MAX_UNITS      = 1 << (IN_WIDTH - 1 - IN_FRAC);
  localparam int N_CORNER       = 16;
  localparam int RANDOM_SAMPLES = 1080;
  localparam int PAUSE_AT       = 500;
  localparam int HOLD_CYCLES    = 160;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 40;

  typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  // [IN_WIDTH-1:0] sample_in, zero padded above
  logic [TDATA_W-1:0] s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  // [15:0] pcm_out
  logic [PCM_WIDTH-1:0] m_axis_tdata;
  logic               m_axis_tlast;

  int mismatches;
  int outstanding;

  int burst_left   = 0;
  bit gapless      = 1'b0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  int corner_samples [N_CORNER] = '{
    0, 1, -1, KNEE, KNEE + 1, -KNEE, -(KNEE + 1), ONE,
    -ONE, 2 * ONE, -(3 * ONE), MAX_POS, -MAX_POS, MIN_NEG, 0, MIN_NEG
  };

  soft_knee_limiter_to_pcm16 #(
    .IN_WIDTH (IN_WIDTH),
    .IN_FRAC  (IN_FRAC)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  skl_pcm_checker #(
    .IN_WIDTH (IN_WIDTH),
    .IN_FRAC  (IN_FRAC)
  ) u_pcm_check (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (s_axis_tvalid),
    .sample_ready (s_axis_tready),
    .sample_data  (s_axis_tdata),
    .sample_last  (s_axis_tlast),
    .pcm_valid    (m_axis_tvalid),
    .pcm_ready    (m_axis_tready),
    .pcm_data     (m_axis_tdata),
    .pcm_last     (m_axis_tlast),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one sample until it is taken, then close the burst if it has run out, unless gapless
  task automatic offer_sample(input logic [IN_WIDTH-1:0] sample, input logic last);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'(sample);
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !gapless) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Draw a sample: full range, near the knee, below it, near whole units, or extreme
  function automatic logic [IN_WIDTH-1:0] random_sample();
    int                  pick;
    int                  mag;
    logic [IN_WIDTH-1:0] word;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      word = IN_WIDTH'($urandom);
    end else begin
      if (pick < 60)      mag = KNEE - 2048 + int'($urandom_range(0, 4096));
      else if (pick < 80) mag = int'($urandom_range(0, KNEE));
      else if (pick < 92) mag = ONE * int'($urandom_range(1, MAX_UNITS - 1)) - 512
                                + int'($urandom_range(0, 1024));
      else                mag = MAX_POS - int'($urandom_range(0, 255));
      word = IN_WIDTH'(($urandom_range(0, 1) != 0) ? -mag : mag);
    end
    return word;
  endfunction

  // Stimulus and verdict
  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner samples back to back
    gapless = 1'b1;
    foreach (corner_samples[n]) offer_sample(IN_WIDTH'(corner_samples[n]), n % 3 == 2);
    gapless = 1'b0;
    hold_request = 1'b1;

    for (i = 0; i < RANDOM_SAMPLES; i++) begin
      if (i == PAUSE_AT) begin
        // hold the input until every request in flight has come back
        s_axis_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(posedge clk);
      end
      gapless = (i >= 700 && i < 850);
      offer_sample(random_sample(), $urandom_range(0, 7) == 0);
    end
    s_axis_tvalid <= 1'b0;

    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_soft_knee_limiter_to_pcm16: PASS");
    end else begin
      $display("tb_soft_knee_limiter_to_pcm16: FAIL");
    end
    $finish;
  end

  // Receiver: spans of always ready, pattern or random stalls, with one long hold-off after the corner samples
  initial begin
    int       span;
    int       c;
    rx_mode_t mode;
    logic [7:0] stall_pattern;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_request && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      span          = $urandom_range(16, 160);
      mode          = rx_mode_t'($urandom_range(0, 2));
      stall_pattern = 8'($urandom) | 8'h01;
      for (c = 0; c < span; c++) begin
        case (mode)
          RX_ALWAYS:  m_axis_tready <= 1'b1;
          RX_PATTERN: m_axis_tready <= stall_pattern[c % 8];
          default:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_soft_knee_limiter_to_pcm16: FAIL");
    $finish;
  end

endmodule
